// ===== src/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared codes, datapath operations and control/status bundles for the
// ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int unsigned IN_W  = 48;
    localparam int unsigned OUT_W = 56;

    localparam logic [3:0] K_CREATE  = 4'd0;
    localparam logic [3:0] K_DESTROY = 4'd1;
    localparam logic [3:0] K_CLEAR   = 4'd2;
    localparam logic [3:0] K_QUERY   = 4'd3;
    localparam logic [3:0] K_GET     = 4'd4;
    localparam logic [3:0] K_LOCATE  = 4'd5;
    localparam logic [3:0] K_PRIOR   = 4'd6;
    localparam logic [3:0] K_NEXT    = 4'd7;
    localparam logic [3:0] K_INSERT  = 4'd8;
    localparam logic [3:0] K_DELETE  = 4'd9;
    localparam logic [3:0] K_REVERSE = 4'd10;
    localparam logic [3:0] K_RFE     = 4'd11;
    localparam logic [3:0] K_SORT    = 4'd12;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_NOLIST = 3'd2;
    localparam logic [2:0] ST_EXISTS = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETST,
        OP_CREATE,
        OP_DESTROY,
        OP_CLEAR,
        OP_GET_RD,
        OP_WB,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_NB_PREV,
        OP_NB_NEXT,
        OP_INS_INIT,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_DEL_INIT,
        OP_DEL_RD0,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_DEL_END,
        OP_REV_INIT,
        OP_REV_RDI,
        OP_REV_RDJ,
        OP_REV_WRI,
        OP_REV_WRJ,
        OP_SRT_INIT,
        OP_SRT_RDK,
        OP_SRT_KEY,
        OP_SRT_RDP,
        OP_SRT_CMP,
        OP_SRT_PUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] st;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic [3:0] kind;
        logic       exists;
        logic       full;
        logic       pos_get_ok;
        logic       pos_ins_ok;
        logic       cnt_gt1;
        logic       i_lt_cnt;
        logic       i_lt_j;
        logic       i_zero;
        logic       i_next_lt_cnt;
        logic       j_ge_pos;
        logic       j_next_lt_cnt;
        logic       j_zero;
        logic       match;
        logic       key_lt;
    } sts_t;

endpackage

// ===== src/ole_dp.sv =====
// ----------------------------------------------------------------------------
// ole_dp
// List datapath: element memory, count, exists flag, walk indexes and
// result registers.
// ----------------------------------------------------------------------------
module ole_dp #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ole_pkg::cmd_t              cmd,
    output ole_pkg::sts_t              sts,
    input  logic [ole_pkg::IN_W-1:0]   req,
    output logic [ole_pkg::OUT_W-1:0]  rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned WW = ((CW > 8) ? CW : 8) + 1;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;

    logic [3:0]    kind_reg;
    logic [7:0]    pos_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] cnt_reg;
    logic          exists_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [31:0]   key_reg;
    logic [31:0]   tmp_reg;
    logic [2:0]    st_reg;
    logic [31:0]   data_reg;
    logic [CW-1:0] found_reg;
    logic [ole_pkg::OUT_W-1:0] rsp_reg;

    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] i_w;
    logic [WW-1:0] j_w;
    logic [AW-1:0] posm1;
    logic [CW-1:0] rfe_idx;
    logic          lt;

    assign pos_w   = WW'(pos_reg);
    assign cnt_w   = WW'(cnt_reg);
    assign i_w     = WW'(i_reg);
    assign j_w     = WW'(j_reg);
    assign posm1   = AW'(pos_w - WW'(1));
    assign rfe_idx = CW'(cnt_w - pos_w);
    assign lt      = $signed(key_reg) < $signed(rdata_reg);

    assign sts.kind          = kind_reg;
    assign sts.exists        = exists_reg;
    assign sts.full          = cnt_w >= WW'(CAPACITY);
    assign sts.pos_get_ok    = (pos_w != '0) && (pos_w <= cnt_w);
    assign sts.pos_ins_ok    = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
    assign sts.cnt_gt1       = cnt_w > WW'(1);
    assign sts.i_lt_cnt      = i_w < cnt_w;
    assign sts.i_lt_j        = i_w < j_w;
    assign sts.i_zero        = i_reg == '0;
    assign sts.i_next_lt_cnt = (i_w + WW'(1)) < cnt_w;
    assign sts.j_ge_pos      = j_w >= pos_w;
    assign sts.j_next_lt_cnt = (j_w + WW'(1)) < cnt_w;
    assign sts.j_zero        = j_reg == '0;
    assign sts.match         = rdata_reg == val_reg;
    assign sts.key_lt        = lt;

    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rdata_reg;
        unique case (cmd.op)
            ole_pkg::OP_GET_RD:  rd_addr = posm1;
            ole_pkg::OP_SCAN_RD: rd_addr = AW'(i_reg);
            ole_pkg::OP_NB_PREV: rd_addr = AW'(i_reg - CW'(1));
            ole_pkg::OP_NB_NEXT: rd_addr = AW'(i_reg + CW'(1));
            ole_pkg::OP_INS_RD:  rd_addr = AW'(j_reg - CW'(1));
            ole_pkg::OP_DEL_RD0: rd_addr = AW'(j_reg);
            ole_pkg::OP_DEL_RD:  rd_addr = AW'(j_reg + CW'(1));
            ole_pkg::OP_REV_RDI: rd_addr = AW'(i_reg);
            ole_pkg::OP_REV_RDJ: rd_addr = AW'(j_reg);
            ole_pkg::OP_SRT_RDK: rd_addr = AW'(i_reg);
            ole_pkg::OP_SRT_RDP: rd_addr = AW'(j_reg - CW'(1));
            ole_pkg::OP_INS_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
            end
            ole_pkg::OP_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = posm1;
                wr_data = val_reg;
            end
            ole_pkg::OP_DEL_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
            end
            ole_pkg::OP_REV_WRI:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(i_reg);
            end
            ole_pkg::OP_REV_WRJ:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                wr_data = tmp_reg;
            end
            ole_pkg::OP_SRT_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                wr_data = lt ? rdata_reg : key_reg;
            end
            ole_pkg::OP_SRT_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                wr_data = key_reg;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            exists_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                ole_pkg::OP_CREATE:
                begin
                    exists_reg <= 1'b1;
                    cnt_reg    <= '0;
                end
                ole_pkg::OP_DESTROY:
                begin
                    exists_reg <= 1'b0;
                    cnt_reg    <= '0;
                end
                ole_pkg::OP_CLEAR:   cnt_reg <= '0;
                ole_pkg::OP_INS_PUT: cnt_reg <= cnt_reg + CW'(1);
                ole_pkg::OP_DEL_END: cnt_reg <= cnt_reg - CW'(1);
                default:             cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ole_pkg::OP_LOAD:
            begin
                kind_reg  <= req[3:0];
                pos_reg   <= req[11:4];
                val_reg   <= req[43:12];
                st_reg    <= ole_pkg::ST_OK;
                data_reg  <= '0;
                found_reg <= '0;
                i_reg     <= '0;
            end
            ole_pkg::OP_SETST: st_reg <= cmd.st;
            ole_pkg::OP_WB:    data_reg <= rdata_reg;
            ole_pkg::OP_SCAN_CMP:
            begin
                if (!sts.match)
                begin
                    i_reg <= i_reg + CW'(1);
                end
                else if (kind_reg == ole_pkg::K_LOCATE)
                begin
                    found_reg <= i_reg + CW'(1);
                end
            end
            ole_pkg::OP_INS_INIT: j_reg <= cnt_reg;
            ole_pkg::OP_INS_WR:   j_reg <= j_reg - CW'(1);
            ole_pkg::OP_DEL_INIT:
            begin
                j_reg <= (kind_reg == ole_pkg::K_DELETE) ? CW'(posm1) : rfe_idx;
            end
            ole_pkg::OP_DEL_WR:   j_reg <= j_reg + CW'(1);
            ole_pkg::OP_REV_INIT:
            begin
                i_reg <= '0;
                j_reg <= cnt_reg - CW'(1);
            end
            ole_pkg::OP_REV_RDJ:  tmp_reg <= rdata_reg;
            ole_pkg::OP_REV_WRJ:
            begin
                i_reg <= i_reg + CW'(1);
                j_reg <= j_reg - CW'(1);
            end
            ole_pkg::OP_SRT_INIT: i_reg <= CW'(1);
            ole_pkg::OP_SRT_KEY:
            begin
                key_reg <= rdata_reg;
                j_reg   <= i_reg;
            end
            ole_pkg::OP_SRT_CMP:
            begin
                if (lt)
                begin
                    j_reg <= j_reg - CW'(1);
                end
                else
                begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            ole_pkg::OP_SRT_PUT:  i_reg <= i_reg + CW'(1);
            default:              i_reg <= i_reg;
        endcase
        if (cmd.fin)
        begin
            rsp_reg <= {4'b0,
                        exists_reg && (cnt_reg == '0),
                        8'(cnt_reg),
                        8'(found_reg),
                        data_reg,
                        st_reg};
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== src/ole_ctrl.sv =====
// ----------------------------------------------------------------------------
// ole_ctrl
// Request sequencer: decodes each request and steps the datapath through
// the memory walk; owns both stream handshakes.
// ----------------------------------------------------------------------------
module ole_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  ole_pkg::sts_t sts,
    output ole_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_SET,
        S_GET_RD,
        S_WB,
        S_SCAN,
        S_SCAN_CMP,
        S_NB_RD,
        S_INS,
        S_INS_WR,
        S_DEL_RD0,
        S_DEL_TAKE,
        S_DEL,
        S_DEL_WR,
        S_REV,
        S_REV_RDJ,
        S_REV_WRI,
        S_REV_WRJ,
        S_SRT,
        S_SRT_KEY,
        S_SRT_RDP,
        S_SRT_CMP,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       valid_reg, valid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        valid_next = valid_reg && !m_tready;
        cmd.op     = ole_pkg::OP_NONE;
        cmd.st     = code_reg;
        cmd.fin    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = ole_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                if (sts.kind == ole_pkg::K_CREATE)
                begin
                    if (sts.exists)
                    begin
                        code_next  = ole_pkg::ST_EXISTS;
                        state_next = S_SET;
                    end
                    else
                    begin
                        cmd.op = ole_pkg::OP_CREATE;
                    end
                end
                else if (sts.kind > ole_pkg::K_SORT)
                begin
                    code_next  = ole_pkg::ST_BAD;
                    state_next = S_SET;
                end
                else if (!sts.exists)
                begin
                    code_next  = ole_pkg::ST_NOLIST;
                    state_next = S_SET;
                end
                else
                begin
                    code_next = ole_pkg::ST_BAD;
                    unique case (sts.kind)
                        ole_pkg::K_DESTROY: cmd.op = ole_pkg::OP_DESTROY;
                        ole_pkg::K_CLEAR:   cmd.op = ole_pkg::OP_CLEAR;
                        ole_pkg::K_GET:
                        begin
                            state_next = sts.pos_get_ok ? S_GET_RD : S_SET;
                        end
                        ole_pkg::K_LOCATE, ole_pkg::K_PRIOR, ole_pkg::K_NEXT:
                        begin
                            state_next = S_SCAN;
                        end
                        ole_pkg::K_INSERT:
                        begin
                            if (sts.full)
                            begin
                                code_next  = ole_pkg::ST_FULL;
                                state_next = S_SET;
                            end
                            else if (sts.pos_ins_ok)
                            begin
                                cmd.op     = ole_pkg::OP_INS_INIT;
                                state_next = S_INS;
                            end
                            else
                            begin
                                state_next = S_SET;
                            end
                        end
                        ole_pkg::K_DELETE, ole_pkg::K_RFE:
                        begin
                            if (sts.pos_get_ok)
                            begin
                                cmd.op     = ole_pkg::OP_DEL_INIT;
                                state_next = S_DEL_RD0;
                            end
                            else
                            begin
                                state_next = S_SET;
                            end
                        end
                        ole_pkg::K_REVERSE:
                        begin
                            if (sts.cnt_gt1)
                            begin
                                cmd.op     = ole_pkg::OP_REV_INIT;
                                state_next = S_REV;
                            end
                        end
                        ole_pkg::K_SORT:
                        begin
                            cmd.op     = ole_pkg::OP_SRT_INIT;
                            state_next = S_SRT;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SET:
            begin
                cmd.op     = ole_pkg::OP_SETST;
                state_next = S_FIN;
            end
            S_GET_RD:
            begin
                cmd.op     = ole_pkg::OP_GET_RD;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op     = ole_pkg::OP_WB;
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = ole_pkg::OP_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    code_next  = ole_pkg::ST_BAD;
                    state_next = S_SET;
                end
            end
            S_SCAN_CMP:
            begin
                cmd.op    = ole_pkg::OP_SCAN_CMP;
                code_next = ole_pkg::ST_BAD;
                if (!sts.match)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.kind == ole_pkg::K_LOCATE)
                begin
                    state_next = S_FIN;
                end
                else if (sts.kind == ole_pkg::K_PRIOR)
                begin
                    state_next = sts.i_zero ? S_SET : S_NB_RD;
                end
                else
                begin
                    state_next = sts.i_next_lt_cnt ? S_NB_RD : S_SET;
                end
            end
            S_NB_RD:
            begin
                cmd.op     = (sts.kind == ole_pkg::K_PRIOR) ? ole_pkg::OP_NB_PREV
                                                            : ole_pkg::OP_NB_NEXT;
                state_next = S_WB;
            end
            S_INS:
            begin
                if (sts.j_ge_pos)
                begin
                    cmd.op     = ole_pkg::OP_INS_RD;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.op     = ole_pkg::OP_INS_PUT;
                    state_next = S_FIN;
                end
            end
            S_INS_WR:
            begin
                cmd.op     = ole_pkg::OP_INS_WR;
                state_next = S_INS;
            end
            S_DEL_RD0:
            begin
                cmd.op     = ole_pkg::OP_DEL_RD0;
                state_next = S_DEL_TAKE;
            end
            S_DEL_TAKE:
            begin
                cmd.op     = ole_pkg::OP_WB;
                state_next = S_DEL;
            end
            S_DEL:
            begin
                if (sts.j_next_lt_cnt)
                begin
                    cmd.op     = ole_pkg::OP_DEL_RD;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cmd.op     = ole_pkg::OP_DEL_END;
                    state_next = S_FIN;
                end
            end
            S_DEL_WR:
            begin
                cmd.op     = ole_pkg::OP_DEL_WR;
                state_next = S_DEL;
            end
            S_REV:
            begin
                if (sts.i_lt_j)
                begin
                    cmd.op     = ole_pkg::OP_REV_RDI;
                    state_next = S_REV_RDJ;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_REV_RDJ:
            begin
                cmd.op     = ole_pkg::OP_REV_RDJ;
                state_next = S_REV_WRI;
            end
            S_REV_WRI:
            begin
                cmd.op     = ole_pkg::OP_REV_WRI;
                state_next = S_REV_WRJ;
            end
            S_REV_WRJ:
            begin
                cmd.op     = ole_pkg::OP_REV_WRJ;
                state_next = S_REV;
            end
            S_SRT:
            begin
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = ole_pkg::OP_SRT_RDK;
                    state_next = S_SRT_KEY;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SRT_KEY:
            begin
                cmd.op     = ole_pkg::OP_SRT_KEY;
                state_next = S_SRT_RDP;
            end
            S_SRT_RDP:
            begin
                if (sts.j_zero)
                begin
                    cmd.op     = ole_pkg::OP_SRT_PUT;
                    state_next = S_SRT;
                end
                else
                begin
                    cmd.op     = ole_pkg::OP_SRT_RDP;
                    state_next = S_SRT_CMP;
                end
            end
            S_SRT_CMP:
            begin
                cmd.op     = ole_pkg::OP_SRT_CMP;
                state_next = sts.key_lt ? S_SRT_RDP : S_SRT;
            end
            S_FIN:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.fin    = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ole_pkg::ST_OK;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== src/ordered_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// One ordered list of signed 32-bit values with create/destroy, search,
// insert, delete, reverse, remove-from-end and ascending sort requests.
// ----------------------------------------------------------------------------
// Search time grows with the entries walked, insert/delete time with the
//   entries moved and reverse time with the pairs swapped.
//   Sort is insertion sort, with a quadratic number of compares at worst.
// Throughput: one request at a time; the next is taken the cycle after the
//   result is registered. Reset: no list, count 0; memory is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // kind[3:0], position[11:4], value[43:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // status[2:0], data_out[34:3],
                                  // found_position[42:35], count[50:43],
                                  // is_empty[51]
);

    ole_pkg::cmd_t cmd;
    ole_pkg::sts_t sts;

    ole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (s_tdata),
        .rsp   (m_tdata)
    );

endmodule
